[sv/mtui_pkg.sv]
// Package with shared types, constants and functions of the MT19937 unit-interval generator.
package mtui_pkg;

  // Fixed widths of the generator words and results.
  localparam int unsigned WORD_W = 32;
  localparam int unsigned FRAC_W = 33;

  // Standard MT19937 constants.
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] SEED_RESET   = 32'd5489;

  // Control states of the top level.
  typedef enum logic [1:0] {
    ST_UNSEEDED,
    ST_SEED,
    ST_FIRST,
    ST_RUN
  } mtui_state_t;

  // Status of the seeding sequencer toward the top level.
  typedef struct packed {
    logic word_valid;
    logic last;
  } seed_stat_t;

  // Twist of one word from the oldest word, its neighbor and the tap word.
  function automatic logic [WORD_W-1:0] twist_word(
    input logic [WORD_W-1:0] w_k,
    input logic [WORD_W-1:0] w_k1,
    input logic [WORD_W-1:0] w_tap
  );
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] v;
    y = (w_k & HIGH_BIT) | (w_k1 & LOW_BITS);
    v = w_tap ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_MATRIX;
    end
    return v;
  endfunction

  // Output tempering of one state word.
  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

[sv/mtui_cell.sv]
// One cell of the state chain: a state word that moves to its neighbor on each shift.
module mtui_cell (
  input  logic                      clk,
  input  logic                      shift_en,
  input  logic [mtui_pkg::WORD_W-1:0] d_in,
  output logic [mtui_pkg::WORD_W-1:0] q
);
  import mtui_pkg::*;

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;

  // Take the neighbor's word when the chain shifts, else hold.
  always_comb begin
    word_nxt = shift_en ? d_in : word_r;
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q = word_r;

endmodule

[sv/mtui_seeder.sv]
// Seeding sequencer: produces the MT19937ar initialization words, one per cycle.
module mtui_seeder #(
  parameter int unsigned STATE_DEPTH = 624
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mtui_pkg::WORD_W-1:0] seed,
  output logic [mtui_pkg::WORD_W-1:0] word,
  output mtui_pkg::seed_stat_t        stat
);
  import mtui_pkg::*;

  localparam int unsigned CNT_W = $clog2(STATE_DEPTH);

  logic             active_r;
  logic             active_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [WORD_W-1:0] prev_r;
  logic [WORD_W-1:0] prev_nxt;
  logic [WORD_W-1:0] mixed;
  logic [WORD_W-1:0] product;
  logic             is_last;

  // Next initialization word from the previous one and the word number.
  always_comb begin
    mixed   = prev_r ^ (prev_r >> 30);
    product = INIT_MULT * mixed;
    word    = (cnt_r == '0) ? seed : (product + WORD_W'(cnt_r));
    is_last = (cnt_r == CNT_W'(STATE_DEPTH - 1));
  end

  // Counter and run flag of the sequence.
  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    prev_nxt   = prev_r;
    if (start) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
    end else if (active_r) begin
      prev_nxt = word;
      cnt_nxt  = cnt_r + 1'b1;
      if (is_last) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
  end

  assign stat.word_valid = active_r;
  assign stat.last       = active_r & is_last;

endmodule

[sv/mersenne_twister_unit_interval_top.sv]
// Top level of the MT19937 generator with open unit-interval numerator output.
// Response: the first request after reset is answered once the seeding pass has filled the
// cell chain and a twist step has run; later requests are answered in the cycle after acceptance.
// Throughput: one result per cycle after seeding while out_ready is high, set by the one-word shift.
// Reset: control, output valid and the seed register (5489) are cleared; the state chain is
// not, and is filled by the seeding pass on the first request.
module mersenne_twister_unit_interval_top #(
  parameter int unsigned STATE_DEPTH = 624,
  parameter int unsigned TAP_OFFSET  = 397
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [mtui_pkg::WORD_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_request,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mtui_pkg::WORD_W-1:0] out_raw_word,
  output logic [mtui_pkg::FRAC_W-1:0] out_fraction_numerator
);
  import mtui_pkg::*;

  mtui_state_t       state_r;
  mtui_state_t       state_nxt;
  logic [WORD_W-1:0] seed_r;
  logic [WORD_W-1:0] seed_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [WORD_W-1:0] raw_r;
  logic [WORD_W-1:0] raw_nxt;

  logic [WORD_W-1:0] chain_q [STATE_DEPTH];
  logic [WORD_W-1:0] feed_word;
  logic [WORD_W-1:0] seed_word;
  logic [WORD_W-1:0] new_word;
  logic              shift_en;
  logic              seed_start;
  logic              in_accept;
  seed_stat_t        seed_stat;

  // Seed register, written whenever the write enable is high.
  always_comb begin
    seed_nxt = cfg_we ? cfg_wdata : seed_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  // Seeding sequencer.
  mtui_seeder #(
    .STATE_DEPTH(STATE_DEPTH)
  ) u_seeder (
    .clk  (clk),
    .rst_n(rst_n),
    .start(seed_start),
    .seed (seed_r),
    .word (seed_word),
    .stat (seed_stat)
  );

  // New word from the taps of the chain.
  assign new_word  = twist_word(chain_q[0], chain_q[1], chain_q[TAP_OFFSET]);
  assign feed_word = (state_r == ST_SEED) ? seed_word : new_word;

  // Row of state cells; the oldest word sits in cell zero.
  for (genvar gi = 0; gi < STATE_DEPTH; gi++) begin : g_cell
    if (gi == STATE_DEPTH - 1) begin : g_tail
      mtui_cell u_cell (
        .clk     (clk),
        .shift_en(shift_en),
        .d_in    (feed_word),
        .q       (chain_q[gi])
      );
    end else begin : g_body
      mtui_cell u_cell (
        .clk     (clk),
        .shift_en(shift_en),
        .d_in    (chain_q[gi+1]),
        .q       (chain_q[gi])
      );
    end
  end

  assign in_accept = in_valid & in_ready;

  // Control state machine, chain shift and output register loads.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    raw_nxt       = raw_r;
    in_ready      = 1'b0;
    shift_en      = 1'b0;
    seed_start    = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_UNSEEDED: begin
        in_ready = 1'b1;
        if (in_accept && in_request) begin
          seed_start = 1'b1;
          state_nxt  = ST_SEED;
        end
      end
      ST_SEED: begin
        shift_en = seed_stat.word_valid;
        if (seed_stat.last) begin
          state_nxt = ST_FIRST;
        end
      end
      ST_FIRST: begin
        shift_en      = 1'b1;
        raw_nxt       = temper(new_word);
        out_valid_nxt = 1'b1;
        state_nxt     = ST_RUN;
      end
      ST_RUN: begin
        in_ready = !out_valid_r || out_ready;
        if (in_accept && in_request) begin
          shift_en      = 1'b1;
          raw_nxt       = temper(new_word);
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_UNSEEDED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_UNSEEDED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r <= raw_nxt;
  end

  // Result ports.
  assign out_valid              = out_valid_r;
  assign out_raw_word           = raw_r;
  assign out_fraction_numerator = {raw_r, 1'b1};

endmodule

[tb/mt_stream_checker.sv]
`timescale 1ns / 1ps
// Checker that predicts the MT19937 output stream and compares every accepted result.
module mt_stream_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [mtui_pkg::WORD_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        in_request,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [mtui_pkg::WORD_W-1:0] out_raw_word,
  input  logic [mtui_pkg::FRAC_W-1:0] out_fraction_numerator,
  output int                          mismatches,
  output int                          pending
);
  import mtui_pkg::WORD_W;
  import mtui_pkg::FRAC_W;

  // Generator geometry and constants of the standard algorithm.
  localparam int              N_WORDS     = 624;
  localparam int              TAP_DIST    = 397;
  localparam int              NOT_SEEDED  = N_WORDS + 1;
  localparam logic [WORD_W-1:0] SEED_MULT  = 32'd1812433253;
  localparam logic [WORD_W-1:0] MAG_A      = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] MASK_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] MASK_C     = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] SEED_AT_RESET = 32'd5489;

  typedef struct {
    logic [WORD_W-1:0] raw;
    logic [FRAC_W-1:0] numerator;
  } drawn_number_t;

  // Local copy of the generator state and the seed register.
  logic [WORD_W-1:0] seed_reg;
  logic [WORD_W-1:0] mt_words [N_WORDS];
  int                word_pos;
  drawn_number_t     owed_numbers [$];
  int                bad_count;
  int                result_no;

  initial begin
    bad_count  = 0;
    result_no  = 0;
    seed_reg   = SEED_AT_RESET;
    word_pos   = NOT_SEEDED;
  end

  // Standard initialization of all state words from one seed.
  function automatic void seed_all(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] prev;
    mt_words[0] = s;
    for (int i = 1; i < N_WORDS; i++) begin
      prev = mt_words[i-1];
      mt_words[i] = SEED_MULT * (prev ^ (prev >> 30)) + WORD_W'(i);
    end
  endfunction

  // Regenerates the whole state in place, word by word.
  function automatic void twist_all();
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] nv;
    for (int k = 0; k < N_WORDS; k++) begin
      mix = (mt_words[k] & UPPER_MASK) | (mt_words[(k + 1) % N_WORDS] & LOWER_MASK);
      nv  = mt_words[(k + TAP_DIST) % N_WORDS] ^ (mix >> 1);
      if (mix[0]) begin
        nv = nv ^ MAG_A;
      end
      mt_words[k] = nv;
    end
  endfunction

  // Output tempering of one state word.
  function automatic logic [WORD_W-1:0] tempered(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] t;
    t = w ^ (w >> 11);
    t = t ^ ((t << 7) & MASK_B);
    t = t ^ ((t << 15) & MASK_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

  // Next number of the stream; seeds on first use and twists when the state is used up.
  function automatic drawn_number_t predict_draw();
    drawn_number_t d;
    if (word_pos >= N_WORDS) begin
      if (word_pos >= NOT_SEEDED) begin
        seed_all(seed_reg);
      end
      twist_all();
      word_pos = 0;
    end
    d.raw       = tempered(mt_words[word_pos]);
    d.numerator = {d.raw, 1'b1};
    word_pos++;
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $realtime, result_no, msg);
    bad_count++;
  endtask

  // Sample all channels at the clock edge: configuration, results, then new requests.
  always @(posedge clk) begin : watch
    drawn_number_t want;
    if (!rst_n) begin
      seed_reg = SEED_AT_RESET;
      word_pos = NOT_SEEDED;
      owed_numbers.delete();
    end else begin
      if (cfg_we) begin
        seed_reg = cfg_wdata;
      end

      // Compare each result transaction with the oldest owed number.
      if (out_valid && out_ready) begin
        if (owed_numbers.size() == 0) begin
          report_mismatch($sformatf("unexpected result raw_word 0x%08h", out_raw_word));
        end else begin
          want = owed_numbers.pop_front();
          if (out_raw_word !== want.raw) begin
            report_mismatch($sformatf("raw_word got 0x%08h, expected 0x%08h",
                                      out_raw_word, want.raw));
          end
          if (out_fraction_numerator !== want.numerator) begin
            report_mismatch($sformatf("fraction_numerator got 0x%09h, expected 0x%09h",
                                      out_fraction_numerator, want.numerator));
          end
        end
        result_no++;
      end

      // A request transaction with the request bit clear leaves the generator alone.
      if (in_valid && in_ready && in_request) begin
        owed_numbers.push_back(predict_draw());
      end
    end
    mismatches <= bad_count;
    pending    <= owed_numbers.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Testbench top that drives the MT19937 generator, paces both channels and gives the verdict.
module tb;
  import mtui_pkg::WORD_W;
  import mtui_pkg::FRAC_W;

  localparam int RESET_CYCLES    = 8;
  localparam int MAX_IDLE        = 14;
  localparam int RANDOM_REQUESTS = 1700;
  localparam int PHASE_ITEMS     = 200;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 8;
  // The limit covers the seeding pass together with the stalls and pauses.
  localparam int QUIET_LIMIT     = 4000;

  localparam logic REQ_NONE = 1'b0;
  localparam logic REQ_NEXT = 1'b1;
  localparam logic [WORD_W-1:0] SEED_DEFAULT = 32'd5489;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [WORD_W-1:0] cfg_wdata = '0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic              in_request = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [WORD_W-1:0] out_raw_word;
  logic [FRAC_W-1:0] out_fraction_numerator;

  int mismatches;
  int pending;
  int stall_left   = 0;
  int quiet_cycles = 0;
  bit steady       = 1'b0;

  mersenne_twister_unit_interval_top dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_request             (in_request),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_raw_word           (out_raw_word),
    .out_fraction_numerator (out_fraction_numerator)
  );

  mt_stream_checker checker_i (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_request             (in_request),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_raw_word           (out_raw_word),
    .out_fraction_numerator (out_fraction_numerator),
    .mismatches             (mismatches),
    .pending                (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: after each result transaction, hold ready low for a random stall.
  always @(posedge clk) begin : receiver
    int draw;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      draw = steady ? 0 : $urandom_range(0, MAX_IDLE);
      stall_left <= draw;
      out_ready  <= (draw == 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_ready  <= 1'b1;
    end
  end

  // Ends the run when no transaction has happened on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One request transaction after a gap; valid stays high when the gap is zero.
  task automatic send_request(input logic req, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_request <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drops valid and waits until every owed result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [WORD_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [WORD_W-1:0] used_seed;
    logic              req;
    int                requests_sent;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Both extreme seeds are written; only the last write before the first request counts.
    write_seed('1);
    write_seed('0);
    // A zero request while unseeded must be ignored.
    send_request(REQ_NONE, 0);
    settle();

    case ($urandom_range(0, 5))
      0: used_seed = '0;
      1: used_seed = '1;
      2: used_seed = SEED_DEFAULT;
      default: used_seed = $urandom;
    endcase
    write_seed(used_seed);

    // Back-to-back requests; the first one starts the seeding pass.
    for (int n = 0; n < 6; n++) send_request(REQ_NEXT, 0);
    // Zero requests interleaved without gaps.
    for (int n = 0; n < 6; n++) send_request((n % 2 == 1) ? REQ_NEXT : REQ_NONE, 0);
    // Longest sender gaps.
    for (int n = 0; n < 6; n++) send_request(REQ_NEXT, MAX_IDLE);
    settle();

    // Seed writes after seeding must leave the stream unchanged.
    write_seed('0);
    write_seed('1);

    // Random phases, some with no idling on either side, each followed by an ignored seed write.
    requests_sent = 0;
    while (requests_sent < RANDOM_REQUESTS) begin
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS && requests_sent < RANDOM_REQUESTS; n++) begin
        req = ($urandom_range(0, 9) != 0) ? REQ_NEXT : REQ_NONE;
        send_request(req, steady ? 0 : $urandom_range(0, MAX_IDLE));
        requests_sent++;
      end
      settle();
      write_seed($urandom);
    end

    steady = 1'b0;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
